/* hw/rtl/perspective_world_to_screen_defines.svh */
// Assertion macros shared by the projection block's RTL files.
`ifndef PERSPECTIVE_WORLD_TO_SCREEN_DEFINES_SVH
`define PERSPECTIVE_WORLD_TO_SCREEN_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define PWS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check that cons holds in the cycle after ante.
`define PWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PWS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define PWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* hw/rtl/pws_pkg.sv */
// Shared widths, defaults and control types of the projection block.
package pws_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned Q_W           = 32;
  localparam int unsigned SIZE_W        = 16;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned CFG_IDX_W     = 2;
  // Four products of up to 64 bits summed without loss.
  localparam int unsigned ACC_W         = 66;

  typedef struct packed {
    logic issue;  // multiply this cycle's operands
    logic clear;  // empty the accumulator
    logic neg;    // subtract this product instead of adding it
    logic half;   // scale result by one half, else by the fraction
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hw/rtl/pws_mac.sv */
// Shared signed multiply-accumulate unit with shifted, saturated result.
module pws_mac #(
  parameter int unsigned FRAC_BITS = pws_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pws_pkg::mac_ctrl_t               ctrl,
  input  logic signed [pws_pkg::Q_W-1:0]   op_a,
  input  logic signed [pws_pkg::Q_W-1:0]   op_b,
  output logic signed [pws_pkg::Q_W-1:0]   result
);
  import pws_pkg::*;

  localparam int unsigned P_W = 2 * Q_W;
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};

  logic signed [P_W-1:0]   prod;
  logic                    prod_vld;
  logic                    prod_neg;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] shifted;

  // Extend the registered product and fold it into the running sum
  assign prod_ext = {{(ACC_W-P_W){prod[P_W-1]}}, prod};
  assign acc_next = prod_neg ? (acc - prod_ext) : (acc + prod_ext);

  // Floor-scale the sum, then clamp to the 32-bit range
  assign shifted = ctrl.half ? (acc >>> 1) : (acc >>> FRAC_BITS);

  always_comb begin
    if (shifted > SAT_MAX) begin
      result = SAT_MAX[Q_W-1:0];
    end else if (shifted < SAT_MIN) begin
      result = SAT_MIN[Q_W-1:0];
    end else begin
      result = shifted[Q_W-1:0];
    end
  end

  // Track which cycles carry a fresh product
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.issue;
    end
  end

  // Multiply, then accumulate the registered product in the next cycle
  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      prod     <= op_a * op_b;
      prod_neg <= ctrl.neg;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc_next;
    end
  end

endmodule

/* hw/rtl/pws_div.sv */
// Radix-4 restoring divider: fixed-point signed quotient, positive divisor, saturated.
`include "perspective_world_to_screen_defines.svh"

module pws_div #(
  parameter int unsigned FRAC_BITS = pws_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [pws_pkg::Q_W-1:0]   num,
  input  logic signed [pws_pkg::Q_W-1:0]   den,
  output pws_pkg::div_stat_t               stat,
  output logic signed [pws_pkg::Q_W-1:0]   quot
);
  import pws_pkg::*;

  localparam int unsigned NUM_W = Q_W + FRAC_BITS;
  localparam int unsigned DIV_W = NUM_W + (NUM_W % 2);
  localparam int unsigned STEPS = DIV_W / 2;
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);
  localparam logic [DIV_W-1:0] POS_LIM = DIV_W'({1'b0, {(Q_W-1){1'b1}}});
  localparam logic [DIV_W-1:0] NEG_LIM = DIV_W'({1'b1, {(Q_W-1){1'b0}}});

  logic [DIV_W-1:0] dvd;
  logic [DIV_W-1:0] dvd_next;
  logic [Q_W-1:0]   rem;
  logic [Q_W-1:0]   rem_next;
  logic [Q_W-1:0]   den_r;
  logic [Q_W-1:0]   num_mag;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [Q_W:0]     dsr;
  logic [Q_W:0]     t1;
  logic [Q_W:0]     r1;
  logic [Q_W:0]     t2;
  logic [Q_W:0]     r2;
  logic             ge1;
  logic             ge2;

  assign num_mag = num[Q_W-1] ? (~num + 1'b1) : num;

  // Two trial subtractions per cycle; quotient bits shift in from the bottom
  assign dsr      = {1'b0, den_r};
  assign t1       = {rem, dvd[DIV_W-1]};
  assign ge1      = (t1 >= dsr);
  assign r1       = ge1 ? (t1 - dsr) : t1;
  assign t2       = {r1[Q_W-1:0], dvd[DIV_W-2]};
  assign ge2      = (t2 >= dsr);
  assign r2       = ge2 ? (t2 - dsr) : t2;
  assign dvd_next = {dvd[DIV_W-3:0], ge1, ge2};
  assign rem_next = r2[Q_W-1:0];

  // Apply the sign and clamp the magnitude
  always_comb begin
    if (neg) begin
      if (dvd > NEG_LIM) begin
        quot = {1'b1, {(Q_W-1){1'b0}}};
      end else begin
        quot = ~dvd[Q_W-1:0] + 1'b1;
      end
    end else begin
      if (dvd > POS_LIM) begin
        quot = {1'b0, {(Q_W-1){1'b1}}};
      end else begin
        quot = dvd[Q_W-1:0];
      end
    end
  end

  // Sequence the steps and pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // Load operands, then advance the partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= DIV_W'({num_mag, {FRAC_BITS{1'b0}}});
      rem   <= '0;
      neg   <= num[Q_W-1];
      den_r <= den;
    end else if (stat.busy) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
  end

  `PWS_ASSERT_NEXT(a_div_start_busy, clk, rst, start, stat.busy, "divider idle after start")
  `PWS_ASSERT_IMPLY(a_div_done_after_busy, clk, rst, stat.done, $past(stat.busy) && !stat.busy, "divider done without a run")

endmodule

/* hw/rtl/perspective_world_to_screen.sv */
// Top level of the perspective world-to-screen projection block.
// Usage:
//   Command channel (cmd_valid/cmd_stall): command 0 loads matrix entry
//   entry_index with entry_value and gives no result; command 1 projects
//   point_x/y/z and gives one result on the result channel.
//   Result channel (res_valid/res_stall): visible, screen_x, screen_y.
//   Config channel (cfg_valid/cfg_ready, always ready): index 0 sets the
//   window width, index 1 the window height; other indices are ignored.
// Operation:
//   A load does not stall the command channel. A projection runs on one
//   shared multiplier and one radix-4 divider: three clip rows, two
//   divisions, then two screen rows, and a write into the output register.
//   A point that is not visible skips the divisions and screen rows; the
//   next command is taken in the cycle the result shows.
//   The command channel stalls for the whole projection.
// Reset clears the matrix and res_valid, and restores 1920 x 1080.
// A stalled result holds; the next command is still taken, and its result
// waits in the block until the output register empties.
`include "perspective_world_to_screen_defines.svh"

module perspective_world_to_screen #(
  parameter int unsigned FRAC_BITS = pws_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic                                command,
  input  logic [pws_pkg::IDX_W-1:0]           entry_index,
  input  logic signed [pws_pkg::Q_W-1:0]      entry_value,
  input  logic signed [pws_pkg::Q_W-1:0]      point_x,
  input  logic signed [pws_pkg::Q_W-1:0]      point_y,
  input  logic signed [pws_pkg::Q_W-1:0]      point_z,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic                                visible,
  output logic signed [pws_pkg::Q_W-1:0]      screen_x,
  output logic signed [pws_pkg::Q_W-1:0]      screen_y,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pws_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pws_pkg::SIZE_W-1:0]          cfg_data
);
  import pws_pkg::*;

  localparam int unsigned MAT_N = 2 ** IDX_W;
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = CFG_IDX_W'(1);
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(1080);
  localparam logic signed [Q_W-1:0] ONE_Q      = Q_W'(1 << FRAC_BITS);
  localparam logic signed [Q_W-1:0] SCALE_TWO  = Q_W'(2);
  localparam logic signed [Q_W-1:0] UNIT       = Q_W'(1);
  localparam logic signed [Q_W-1:0] W_THRESH   = Q_W'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [1:0] ROW_X = 2'd0;
  localparam logic [1:0] ROW_Y = 2'd1;
  localparam logic [1:0] ROW_W = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_LAST, ST_SAVE, ST_DIV, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_CX, PH_CY, PH_CW, PH_SX, PH_SY
  } phase_t;

  state_t                  state;
  phase_t                  phase;
  logic [1:0]              term;
  logic [1:0]              last_term;
  logic [1:0]              row;
  logic                    div_sel;
  logic [SIZE_W-1:0]       win_w;
  logic [SIZE_W-1:0]       win_h;
  logic signed [Q_W-1:0]   matrix [MAT_N];
  logic signed [Q_W-1:0]   mat_rd;
  logic signed [Q_W-1:0]   px;
  logic signed [Q_W-1:0]   py;
  logic signed [Q_W-1:0]   pz;
  logic signed [Q_W-1:0]   cx;
  logic signed [Q_W-1:0]   cy;
  logic signed [Q_W-1:0]   cw;
  logic signed [Q_W-1:0]   nx;
  logic signed [Q_W-1:0]   ny;
  logic signed [Q_W-1:0]   sx;
  logic signed [Q_W-1:0]   sy;
  logic                    vis;
  logic signed [Q_W-1:0]   w_ext;
  logic signed [Q_W-1:0]   h_ext;
  logic                    accept;
  logic                    below;
  mac_ctrl_t               mac_ctrl;
  logic signed [Q_W-1:0]   op_a;
  logic signed [Q_W-1:0]   op_b;
  logic signed [Q_W-1:0]   mac_result;
  logic                    div_start;
  logic signed [Q_W-1:0]   div_num;
  logic signed [Q_W-1:0]   div_den;
  div_stat_t               div_stat;
  logic signed [Q_W-1:0]   div_quot;

  assign cmd_stall = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = cmd_valid && !cmd_stall;
  assign w_ext     = {{(Q_W-SIZE_W){1'b0}}, win_w};
  assign h_ext     = {{(Q_W-SIZE_W){1'b0}}, win_h};
  assign below     = (mac_result < W_THRESH);

  // Pick the matrix row for this clip pass
  always_comb begin
    case (phase)
      PH_CX:   row = ROW_X;
      PH_CY:   row = ROW_Y;
      default: row = ROW_W;
    endcase
  end

  assign mat_rd    = matrix[{row, term}];
  assign last_term = (phase == PH_SX) ? 2'd2 : 2'd3;

  // Select multiplier operands and controls for each term of the current pass
  always_comb begin
    op_a = '0;
    op_b = '0;
    mac_ctrl.issue = (state == ST_MUL);
    mac_ctrl.clear = (state == ST_MUL) && (term == 2'd0);
    mac_ctrl.half  = (phase == PH_SX) || (phase == PH_SY);
    mac_ctrl.neg   = 1'b0;
    case (phase) inside
      PH_CX, PH_CY, PH_CW: begin
        case (term)
          2'd0:    begin op_a = px;     op_b = mat_rd; end
          2'd1:    begin op_a = py;     op_b = mat_rd; end
          2'd2:    begin op_a = pz;     op_b = mat_rd; end
          default: begin op_a = mat_rd; op_b = ONE_Q;  end
        endcase
      end
      PH_SX: begin
        case (term)
          2'd0:    begin op_a = w_ext; op_b = nx;        end
          2'd1:    begin op_a = nx;    op_b = SCALE_TWO; end
          default: begin op_a = w_ext; op_b = ONE_Q;     end
        endcase
      end
      default: begin
        // Negated half-height term; the unit term turns the floor into a ceiling
        case (term)
          2'd0:    begin op_a = h_ext; op_b = ny; mac_ctrl.neg = 1'b1; end
          2'd1:    begin op_a = ny;    op_b = SCALE_TWO; end
          2'd2:    begin op_a = h_ext; op_b = ONE_Q;     end
          default: begin op_a = UNIT;  op_b = UNIT;      end
        endcase
      end
    endcase
  end

  pws_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .op_a   (op_a),
    .op_b   (op_b),
    .result (mac_result)
  );

  // Start on x after the w pass, then on y when x completes
  assign div_start = ((state == ST_SAVE) && (phase == PH_CW) && !below) ||
                     ((state == ST_DIV) && div_stat.done && !div_sel);
  assign div_num   = (state == ST_DIV) ? cy : cx;
  assign div_den   = (state == ST_SAVE) ? mac_result : cw;

  pws_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // Hold window size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_w <= WIDTH_RESET;
      win_h <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_WIDTH:  win_w <= cfg_data;
        REG_WINDOW_HEIGHT: win_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the view matrix; loads write one entry
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAT_N; i++) begin
        matrix[i] <= '0;
      end
    end else if (accept && (command == CMD_LOAD)) begin
      matrix[entry_index] <= entry_value;
    end
  end

  // Capture the point and each pass's result
  always_ff @(posedge clk) begin
    if (accept) begin
      px <= point_x;
      py <= point_y;
      pz <= point_z;
    end
    if (state == ST_SAVE) begin
      case (phase)
        PH_CX: cx <= mac_result;
        PH_CY: cy <= mac_result;
        PH_CW: begin
          cw  <= mac_result;
          vis <= !below;
          sx  <= '0;
          sy  <= '0;
        end
        PH_SX:   sx <= mac_result;
        default: sy <= mac_result;
      endcase
    end
    if ((state == ST_DIV) && div_stat.done) begin
      if (div_sel) begin
        ny <= div_quot;
      end else begin
        nx <= div_quot;
      end
    end
  end

  // Sequence the passes and drive the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_CX;
      term      <= 2'd0;
      div_sel   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // Drop a taken result unless a new one replaces it this cycle
      if (res_valid && !res_stall && (state != ST_OUT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (command == CMD_PROJECT)) begin
            state <= ST_MUL;
            phase <= PH_CX;
            term  <= 2'd0;
          end
        end
        ST_MUL: begin
          if (term == last_term) begin
            state <= ST_LAST;
            term  <= 2'd0;
          end else begin
            term <= term + 1'b1;
          end
        end
        ST_LAST: state <= ST_SAVE;
        ST_SAVE: begin
          unique case (phase)
            PH_CX: begin
              phase <= PH_CY;
              state <= ST_MUL;
            end
            PH_CY: begin
              phase <= PH_CW;
              state <= ST_MUL;
            end
            PH_CW: begin
              if (below) begin
                state <= ST_OUT;
              end else begin
                state   <= ST_DIV;
                div_sel <= 1'b0;
              end
            end
            PH_SX: begin
              phase <= PH_SY;
              state <= ST_MUL;
            end
            PH_SY:   state <= ST_OUT;
            default: state <= ST_IDLE;
          endcase
        end
        ST_DIV: begin
          if (div_stat.done) begin
            if (!div_sel) begin
              div_sel <= 1'b1;
            end else begin
              phase <= PH_SX;
              state <= ST_MUL;
            end
          end
        end
        ST_OUT: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            visible   <= vis;
            screen_x  <= sx;
            screen_y  <= sy;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `PWS_ASSERT_IMPLY(a_div_start_idle, clk, rst, div_start, !div_stat.busy, "divider restarted while busy")
  `PWS_ASSERT_IMPLY(a_hidden_zero, clk, rst, res_valid && !visible, screen_x == '0 && screen_y == '0, "hidden point with coordinates")
  `PWS_ASSERT_NEXT(a_project_start, clk, rst, accept && (command == CMD_PROJECT), (state == ST_MUL) && (phase == PH_CX) && (term == 2'd0), "projection did not start")

endmodule
